// ===== design/nfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared types and constants of the next-fit page allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int DEF_NUM_PAGES  = 512;
  localparam int DEF_PAGE_BYTES = 4096;

  // used-bit store is organised as words of WORD_BITS pages
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;
  localparam int REQ_W   = 32;
  localparam int ADDR_W  = 21;
  localparam int STS_W   = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STS_W-1:0] STATUS_NO_PAGE      = 2'd1;
  localparam logic [STS_W-1:0] STATUS_TOO_LARGE    = 2'd2;
  localparam logic [STS_W-1:0] STATUS_FREE_IGNORED = 2'd3;

  localparam logic [CIDX_W-1:0] REG_A_FIRST = 2'd0;
  localparam logic [CIDX_W-1:0] REG_A_LAST  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_B_FIRST = 2'd2;
  localparam logic [CIDX_W-1:0] REG_B_LAST  = 2'd3;

  localparam logic [CFG_W-1:0] RST_A_FIRST = 9'd64;
  localparam logic [CFG_W-1:0] RST_A_LAST  = 9'd127;
  localparam logic [CFG_W-1:0] RST_B_FIRST = 9'd160;
  localparam logic [CFG_W-1:0] RST_B_LAST  = 9'd255;

  typedef struct packed {
    logic [CFG_W-1:0] a_first;
    logic [CFG_W-1:0] a_last;
    logic [CFG_W-1:0] b_first;
    logic [CFG_W-1:0] b_last;
  } cfg_t;

endpackage

// ===== design/nfpa_if.sv =====
// ----------------------------------------------------------------------------
// nfpa_if
// Request and response channels of the page allocator.
// ----------------------------------------------------------------------------
interface nfpa_req_if;
  import nfpa_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [REQ_W-1:0] request_bytes;
  logic [REQ_W-1:0] free_address;

  modport source (output valid, output opcode, output request_bytes,
                  output free_address, input ready);
  modport sink   (input valid, input opcode, input request_bytes,
                  input free_address, output ready);
endinterface

interface nfpa_rsp_if;
  import nfpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, output status, output page_address, input ready);
  modport sink   (input valid, input status, input page_address, output ready);
endinterface

// ===== design/next_fit_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// next_fit_page_allocator_top
// Next-fit page-frame allocator over a word-organised used-bit memory.
// ----------------------------------------------------------------------------
// Allocate: visits 1 .. NUM_PAGES/32 + 1 used-bit words (17 at 512 pages);
//   one used-bit word is read and checked per cycle.
// Free requests pass a read-and-clear state; rejected requests respond directly.
// Result is held in an output register.
// Reset: synchronous; a clearing pass over every used-bit word zeroes the
//   used bits, during which no item is accepted (config writes still taken).
module next_fit_page_allocator_top #(
  parameter int NUM_PAGES  = nfpa_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BYTES = nfpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [nfpa_pkg::CIDX_W-1:0] cfg_index,
  input  logic [nfpa_pkg::CFG_W-1:0]  cfg_data,
  nfpa_req_if.sink                    req,
  nfpa_rsp_if.source                  rsp
);
  import nfpa_pkg::*;

  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PIDX_W    = WORD_AW + BIT_W;
  localparam int VCNT_W    = $clog2(NUM_WORDS + 1);
  localparam int OFF_W     = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FREE, S_RESP
  } state_t;

  state_t               state;
  cfg_t                 cfg;
  logic [WORD_AW-1:0]   clr_addr;
  logic [PIDX_W-1:0]    cursor;
  logic [WORD_AW-1:0]   rd_word;
  logic [VCNT_W-1:0]    vcnt;
  logic [BIT_W-1:0]     free_bit;
  logic [STS_W-1:0]     res_status;
  logic [ADDR_W-1:0]    res_addr;

  logic                 accept;
  logic [WORD_AW-1:0]   cur_word;
  logic [WORD_AW-1:0]   nxt_word;
  logic [PIDX_W-1:0]    fr_page;
  logic                 fr_ok;
  logic [WORD_AW-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;
  logic                 we;
  logic [WORD_AW-1:0]   waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [PIDX_W-1:0]    hit_page;
  logic [PIDX_W-1:0]    cursor_next;
  logic [63:0]          hit_bytes;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign cur_word = cursor[PIDX_W-1:BIT_W];
  assign nxt_word = (rd_word == WORD_AW'(NUM_WORDS - 1)) ? '0 : rd_word + 1'b1;

  assign fr_page = PIDX_W'(req.free_address >> OFF_W);
  assign fr_ok   = (req.free_address != '0) &&
                   (req.free_address[OFF_W-1:0] == '0) &&
                   ((req.free_address >> OFF_W) < 32'(NUM_PAGES));

  assign hit_page    = {rd_word, hit_bit};
  assign cursor_next = (hit_page == PIDX_W'(NUM_PAGES - 1)) ? '0 : hit_page + 1'b1;
  assign hit_bytes   = 64'(hit_page) << OFF_W;

  // next word is fetched every scan cycle; a fetch after a hit is dropped
  always_comb begin
    if (state == S_IDLE) begin
      raddr = (req.opcode == OP_FREE) ? fr_page[PIDX_W-1:BIT_W] : cur_word;
    end else begin
      raddr = nxt_word;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rd_word;
    wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_SCAN: begin
        we    = hit;
        wdata = rdata | (WORD_BITS'(1) << hit_bit);
      end
      S_FREE: begin
        we    = rdata[free_bit];
        wdata = rdata & ~(WORD_BITS'(1) << free_bit);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  nfpa_mem #(
    .DEPTH (NUM_WORDS),
    .AW    (WORD_AW),
    .W     (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  nfpa_pick #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_AW   (WORD_AW)
  ) u_pick (
    .used    (rdata),
    .word    (rd_word),
    .first   (vcnt == '0),
    .offset  (cursor[BIT_W-1:0]),
    .cfg     (cfg),
    .hit     (hit),
    .bit_idx (hit_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      cursor      <= '0;
      cfg.a_first <= RST_A_FIRST;
      cfg.a_last  <= RST_A_LAST;
      cfg.b_first <= RST_B_FIRST;
      cfg.b_last  <= RST_B_LAST;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_A_FIRST: cfg.a_first <= cfg_data;
          REG_A_LAST:  cfg.a_last  <= cfg_data;
          REG_B_FIRST: cfg.b_first <= cfg_data;
          REG_B_LAST:  cfg.b_last  <= cfg_data;
          default:     cfg.a_first <= cfg.a_first;
        endcase
      end

      // the response state reloads the output register itself
      if (rsp.valid && rsp.ready && state != S_RESP) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WORD_AW'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_addr <= '0;
            if (req.opcode == OP_ALLOC) begin
              if (req.request_bytes > 32'(PAGE_BYTES)) begin
                res_status <= STATUS_TOO_LARGE;
                state      <= S_RESP;
              end else begin
                rd_word <= cur_word;
                vcnt    <= '0;
                state   <= S_SCAN;
              end
            end else begin
              rd_word  <= fr_page[PIDX_W-1:BIT_W];
              free_bit <= fr_page[BIT_W-1:0];
              if (fr_ok) begin
                state <= S_FREE;
              end else begin
                res_status <= STATUS_FREE_IGNORED;
                state      <= S_RESP;
              end
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            cursor     <= cursor_next;
            res_status <= STATUS_OK;
            res_addr   <= hit_bytes[ADDR_W-1:0];
            state      <= S_RESP;
          end else if (vcnt == VCNT_W'(NUM_WORDS)) begin
            // start word seen twice: every page has been checked
            res_status <= STATUS_NO_PAGE;
            state      <= S_RESP;
          end else begin
            vcnt    <= vcnt + 1'b1;
            rd_word <= nxt_word;
          end
        end
        S_FREE: begin
          res_status <= rdata[free_bit] ? STATUS_OK : STATUS_FREE_IGNORED;
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.page_address <= res_addr;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/nfpa_mem.sv =====
// ----------------------------------------------------------------------------
// nfpa_mem
// Used-bit store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfpa_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nfpa_pick.sv =====
// ----------------------------------------------------------------------------
// nfpa_pick
// Finds the lowest free, allocatable page in one word of used bits.
// ----------------------------------------------------------------------------
module nfpa_pick #(
  parameter int NUM_PAGES = 512,
  parameter int WORD_AW   = 4
) (
  input  logic [nfpa_pkg::WORD_BITS-1:0] used,
  input  logic [WORD_AW-1:0]             word,
  input  logic                           first,
  input  logic [nfpa_pkg::BIT_W-1:0]     offset,
  input  nfpa_pkg::cfg_t                 cfg,
  output logic                           hit,
  output logic [nfpa_pkg::BIT_W-1:0]     bit_idx
);
  import nfpa_pkg::*;

  logic [WORD_BITS-1:0] cand;

  always_comb begin
    logic [31:0] p;
    logic        in_a;
    logic        in_b;
    for (int i = 0; i < WORD_BITS; i++) begin
      p    = 32'({word, BIT_W'(i)});
      in_a = (cfg.a_first <= cfg.a_last) && (p >= 32'(cfg.a_first)) &&
             (p <= 32'(cfg.a_last));
      in_b = (cfg.b_first <= cfg.b_last) && (p >= 32'(cfg.b_first)) &&
             (p <= 32'(cfg.b_last));
      // first visit of the start word only covers pages at or after the cursor
      cand[i] = (p != 32'd0) && (p < 32'(NUM_PAGES)) && !in_a && !in_b &&
                !used[i] && (!first || (BIT_W'(i) >= offset));
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        bit_idx = BIT_W'(i);
      end
    end
  end

  assign hit = |cand;

endmodule
